// File: rtl/assert_macros.svh
// Assertion helpers for the control request responder.
// Every property is sampled on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define UCRR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ucrr assertion failed");

`define UCRR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucrr implication failed");

`define UCRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucrr next-cycle check failed");

`else

`define UCRR_ASSERT(label, prop)
`define UCRR_ASSERT_IMPL(label, ante, cons)
`define UCRR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/ucrr_pkg.sv
`timescale 1ns / 1ps

package ucrr_pkg;

  // setup byte 0 type field
  localparam logic [7:0] TYPE_MASK     = 8'h60;
  localparam logic [7:0] TYPE_STANDARD = 8'h00;
  localparam logic [7:0] TYPE_CLASS    = 8'h20;

  // request numbers
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_SET_LINE    = 8'h22;

  localparam logic [6:0] ADDR_MASK = 7'h7F;

  // descriptor type codes in the high byte of the value word
  localparam logic [7:0] DTYPE_DEVICE = 8'd1;
  localparam logic [7:0] DTYPE_CONFIG = 8'd2;
  localparam logic [7:0] DTYPE_STRING = 8'd3;
  localparam logic [7:0] NUM_STRINGS  = 8'd4;

  // descriptor lengths in bytes
  localparam logic [6:0] LEN_DEVICE   = 7'd18;
  localparam logic [6:0] LEN_CONFIG   = 7'd67;
  localparam logic [6:0] LEN_LANGUAGE = 7'd4;
  localparam logic [6:0] LEN_MAKER    = 7'd22;
  localparam logic [6:0] LEN_PRODUCT  = 7'd44;
  localparam logic [6:0] LEN_SERIAL   = 7'd18;

  typedef enum logic [1:0] {
    EVT_SETUP     = 2'd0,
    EVT_BUS_RESET = 2'd1,
    EVT_SUSPEND   = 2'd2,
    EVT_UNUSED    = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_STATUS = 2'd1,
    ACT_DESC   = 2'd2,
    ACT_STALL  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    DESC_NONE     = 3'd0,
    DESC_DEVICE   = 3'd1,
    DESC_CONFIG   = 3'd2,
    DESC_LANGUAGE = 3'd3,
    DESC_MAKER    = 3'd4,
    DESC_PRODUCT  = 3'd5,
    DESC_SERIAL   = 3'd6
  } desc_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  request_kind_byte;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
  } req_t;

  typedef struct packed {
    logic [1:0] reply_action;
    logic [2:0] descriptor_select;
    logic [6:0] byte_count;
    logic [6:0] device_address;
    logic       is_configured;
    logic       link_ready;
  } rsp_t;

  typedef struct packed {
    logic [6:0] address;
    logic       configured;
    logic       line_open;
  } dev_state_t;

  typedef struct packed {
    desc_e      sel;
    logic [6:0] len;
  } desc_hit_t;

  // Descriptor table; sel stays DESC_NONE on a miss.
  function automatic desc_hit_t desc_lookup(input logic [15:0] value);
    desc_hit_t  hit;
    logic [7:0] dtype;
    logic [7:0] didx;
    dtype    = value[15:8];
    didx     = value[7:0];
    hit.sel  = DESC_NONE;
    hit.len  = 7'd0;
    if (dtype == DTYPE_DEVICE) begin
      hit.sel = DESC_DEVICE;
      hit.len = LEN_DEVICE;
    end else if (dtype == DTYPE_CONFIG) begin
      hit.sel = DESC_CONFIG;
      hit.len = LEN_CONFIG;
    end else if (dtype == DTYPE_STRING && didx < NUM_STRINGS) begin
      case (didx[1:0])
        2'd0: begin
          hit.sel = DESC_LANGUAGE;
          hit.len = LEN_LANGUAGE;
        end
        2'd1: begin
          hit.sel = DESC_MAKER;
          hit.len = LEN_MAKER;
        end
        2'd2: begin
          hit.sel = DESC_PRODUCT;
          hit.len = LEN_PRODUCT;
        end
        default: begin
          hit.sel = DESC_SERIAL;
          hit.len = LEN_SERIAL;
        end
      endcase
    end
    return hit;
  endfunction

endpackage

// File: rtl/ucrr_decode.sv
`timescale 1ns / 1ps

// Request decode: reply and next device state for one event.
module ucrr_decode
  import ucrr_pkg::*;
(
  input  req_t       item_i,
  input  dev_state_t state_i,
  output dev_state_t state_nxt_o,
  output rsp_t       rsp_o
);

  logic [7:0] rtype;
  desc_hit_t  hit;
  action_e    action;
  desc_e      sel;
  logic [6:0] count;
  dev_state_t nxt;

  assign rtype = item_i.request_kind_byte & TYPE_MASK;
  assign hit   = desc_lookup(item_i.request_value);

  always_comb begin
    nxt    = state_i;
    action = ACT_NONE;
    sel    = DESC_NONE;
    count  = 7'd0;
    case (event_e'(item_i.req_type))
      EVT_SETUP: begin
        action = ACT_STALL;
        if (rtype == TYPE_STANDARD) begin
          if (item_i.request_code == REQ_SET_ADDRESS) begin
            nxt.address = item_i.request_value[6:0] & ADDR_MASK;
            action      = ACT_STATUS;
          end else if (item_i.request_code == REQ_SET_CONFIG) begin
            nxt.configured = 1'b1;
            action         = ACT_STATUS;
          end else if (item_i.request_code == REQ_GET_DESC) begin
            if (hit.sel != DESC_NONE) begin
              sel    = hit.sel;
              action = ACT_DESC;
              // clamp to the host's length
              if (item_i.request_length < {9'd0, hit.len}) begin
                count = item_i.request_length[6:0];
              end else begin
                count = hit.len;
              end
            end
          end
        end else if (rtype == TYPE_CLASS) begin
          if (item_i.request_code == REQ_SET_LINE) begin
            nxt.line_open = item_i.request_value[0];
          end
          action = ACT_STATUS;
        end
      end
      EVT_BUS_RESET: begin
        nxt.address    = 7'd0;
        nxt.configured = 1'b0;
      end
      EVT_SUSPEND: begin
        nxt.line_open = 1'b0;
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_nxt_o              = nxt;
  assign rsp_o.reply_action       = action;
  assign rsp_o.descriptor_select  = sel;
  assign rsp_o.byte_count         = count;
  assign rsp_o.device_address     = nxt.address;
  assign rsp_o.is_configured      = nxt.configured;
  assign rsp_o.link_ready         = nxt.configured & nxt.line_open;

endmodule

// File: rtl/usb_control_request_responder.sv
`timescale 1ns / 1ps
// A result is registered: an event transfers into the input register, then
// moves through the decode into the result register once that register is free.
// Throughput: one event per cycle while out_ready_i stays high; the decode
// between the two registers is a single pass of compare and select logic.
// Reset (rst_ni low, asynchronous): pipeline empties, address, configured
// and line-open flags clear to zero.
`include "assert_macros.svh"

module usb_control_request_responder
  import ucrr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,

  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,

  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  // Stage 1: registered event
  logic       s1_valid_q;
  req_t       s1_item_q;

  // Device state, updated when the stage-1 event moves to the result register
  dev_state_t state_q;
  dev_state_t state_d;

  // Result register
  logic       out_valid_q;
  rsp_t       out_data_q;
  rsp_t       out_data_d;

  logic       s1_advance;
  logic       in_fire;
  logic       out_free;

  // Assertion helpers
  logic       rsp_plain;
  logic       rsp_desc_clear;

  // Result register can take a new value when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && out_free;
  // Stage 1 takes a transfer when empty or when its item moves on this cycle.
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  ucrr_decode u_decode (
    .item_i      (s1_item_q),
    .state_i     (state_q),
    .state_nxt_o (state_d),
    .rsp_o       (out_data_d)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
    if (s1_advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign rsp_plain      = out_valid_q && (out_data_q.reply_action != ACT_DESC);
  assign rsp_desc_clear = (out_data_q.descriptor_select == DESC_NONE) &&
                          (out_data_q.byte_count == 7'd0);

  // Only a descriptor reply carries select and count.
  `UCRR_ASSERT_IMPL(a_desc_fields_zero, rsp_plain, rsp_desc_clear)
  // Link ready implies configured.
  `UCRR_ASSERT_IMPL(a_link_needs_config, out_valid_q && out_data_q.link_ready, out_data_q.is_configured)
  // A stage-1 event blocked by a stalled result register is not dropped.
  `UCRR_ASSERT_NEXT(a_s1_held, s1_valid_q && !out_free, s1_valid_q && $stable(s1_item_q))
  // Descriptor count never exceeds the longest descriptor.
  `UCRR_ASSERT(a_count_range, !out_valid_q || out_data_q.byte_count <= LEN_CONFIG)

endmodule

// File: bench/tb_usb_control_request_responder.sv
`timescale 1ns / 1ps

module tb_usb_control_request_responder;
  import ucrr_pkg::*;

  localparam int EVENT_COUNT  = 400;   // random events other than the unused kind
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int SETTLE       = 8;     // pipeline is two deep; a few spare cycles

  // Device-side model: tracks address / configured / line-open and predicts
  // the reply for every accepted event, then matches replies in order.
  class control_reply_tracker;
    logic [6:0] dev_addr;
    logic       dev_configured;
    logic       line_open;
    rsp_t       pending_replies[$];
    int         mismatches;

    function new();
      dev_addr       = '0;
      dev_configured = 1'b0;
      line_open      = 1'b0;
      mismatches     = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void absorb_event(req_t r);
      rsp_t       e;
      logic [6:0] str_len [4];
      logic [6:0] full_len;
      logic [7:0] dtype;
      logic [7:0] didx;
      str_len  = '{LEN_LANGUAGE, LEN_MAKER, LEN_PRODUCT, LEN_SERIAL};
      e        = '0;
      full_len = '0;
      dtype    = r.request_value[15:8];
      didx     = r.request_value[7:0];
      e.reply_action      = ACT_NONE;
      e.descriptor_select = DESC_NONE;
      case (event_e'(r.req_type))
        EVT_SETUP: begin
          e.reply_action = ACT_STALL;
          if ((r.request_kind_byte & TYPE_MASK) == TYPE_STANDARD) begin
            if (r.request_code == REQ_SET_ADDRESS) begin
              dev_addr       = r.request_value[6:0];
              e.reply_action = ACT_STATUS;
            end else if (r.request_code == REQ_SET_CONFIG) begin
              dev_configured = 1'b1;
              e.reply_action = ACT_STATUS;
            end else if (r.request_code == REQ_GET_DESC) begin
              if (dtype == DTYPE_DEVICE) begin
                e.descriptor_select = DESC_DEVICE;
                full_len            = LEN_DEVICE;
              end else if (dtype == DTYPE_CONFIG) begin
                e.descriptor_select = DESC_CONFIG;
                full_len            = LEN_CONFIG;
              end else if (dtype == DTYPE_STRING && didx < NUM_STRINGS) begin
                e.descriptor_select = DESC_LANGUAGE + didx[1:0];
                full_len            = str_len[didx[1:0]];
              end
              if (e.descriptor_select != DESC_NONE) begin
                e.reply_action = ACT_DESC;
                // clamp on the full 16-bit length word
                e.byte_count = (r.request_length < {9'd0, full_len}) ?
                               r.request_length[6:0] : full_len;
              end
            end
          end else if ((r.request_kind_byte & TYPE_MASK) == TYPE_CLASS) begin
            if (r.request_code == REQ_SET_LINE) line_open = r.request_value[0];
            e.reply_action = ACT_STATUS;
          end
        end
        EVT_BUS_RESET: begin
          dev_addr       = '0;
          dev_configured = 1'b0;
        end
        EVT_SUSPEND: line_open = 1'b0;
        default: ;
      endcase
      e.device_address = dev_addr;
      e.is_configured  = dev_configured;
      e.link_ready     = dev_configured & line_open;
      pending_replies.push_back(e);
    endfunction

    function void compare_field(string nm, logic [6:0] exp_v, logic [6:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, nm, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_reply(rsp_t got);
      rsp_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing expected: expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      compare_field("reply_action", 7'(e.reply_action), 7'(got.reply_action));
      compare_field("descriptor_select", 7'(e.descriptor_select),
                    7'(got.descriptor_select));
      compare_field("byte_count", e.byte_count, got.byte_count);
      compare_field("device_address", e.device_address, got.device_address);
      compare_field("is_configured", 7'(e.is_configured), 7'(got.is_configured));
      compare_field("link_ready", 7'(e.link_ready), 7'(got.link_ready));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  control_reply_tracker tracker;
  bit hold_req = 1'b0;   // raised by the sender, cleared by the receiver
  int burst_left = 0;

  usb_control_request_responder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reply side: every accepted reply is checked against the oldest prediction.
  // Sampling at the rising edge sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.match_reply(out_data);
  end

  // Receiver back-pressure. Works in phases of random length, each with its own
  // mode; a hold-off request parks ready low for a long stretch so the block
  // fills and drops in_ready while the sender keeps offering.
  initial begin
    int          mode;
    int          phase_left;
    logic [31:0] pattern;
    mode       = 0;
    phase_left = 0;
    pattern    = '0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(8, 64);
        pattern    = $urandom;
      end
      phase_left--;
      case (mode)
        0: out_ready <= 1'b1;                          // no stalls at all
        1: out_ready <= pattern[phase_left % 32];      // fixed bit pattern
        2: out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog: any transfer on either side resets the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic req_t setup_pkt(logic [7:0] kind, logic [7:0] code,
                                     logic [15:0] value, logic [15:0] len);
    req_t r;
    r.req_type          = EVT_SETUP;
    r.request_kind_byte = kind;
    r.request_code      = code;
    r.request_value     = value;
    r.request_length    = len;
    return r;
  endfunction

  function automatic logic [15:0] pick_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) return 16'($urandom);
    if (p < 65) return 16'($urandom_range(0, 80));
    if (p < 75) return 16'h0000;
    if (p < 85) return 16'hFFFF;
    return 16'($urandom_range(1, 20));
  endfunction

  // Random event: mostly well-formed setup packets aimed at the decoded
  // requests, with bus resets, suspends, unused kinds and junk mixed in.
  function automatic req_t random_event();
    req_t        r;
    int          p;
    logic [7:0]  dtype;
    logic [7:0]  didx;
    r = req_t'(50'({$urandom, $urandom}));
    p = $urandom_range(0, 99);
    if (p >= 94) r.req_type = EVT_UNUSED;
    else if (p >= 87) r.req_type = EVT_SUSPEND;
    else if (p >= 80) r.req_type = EVT_BUS_RESET;
    else begin
      r.req_type = EVT_SETUP;
      p = $urandom_range(0, 99);
      if (p < 55) begin
        // standard: direction and recipient bits random, type bits zero
        r.request_kind_byte = {r.request_kind_byte[7], 2'b00, r.request_kind_byte[4:0]};
        case ($urandom_range(0, 5))
          0: r.request_code = REQ_SET_ADDRESS;
          1: r.request_code = REQ_SET_CONFIG;
          2, 3, 4: r.request_code = REQ_GET_DESC;
          default: ;
        endcase
        if (r.request_code == REQ_GET_DESC) begin
          case ($urandom_range(0, 5))
            0: dtype = DTYPE_DEVICE;
            1: dtype = DTYPE_CONFIG;
            2, 3, 4: dtype = DTYPE_STRING;
            default: dtype = 8'($urandom);
          endcase
          didx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
          r.request_value = {dtype, didx};
        end
      end else if (p < 85) begin
        r.request_kind_byte = {r.request_kind_byte[7], 2'b01, r.request_kind_byte[4:0]};
        if ($urandom_range(0, 1) == 0) r.request_code = REQ_SET_LINE;
      end
      r.request_length = pick_length();
    end
    return r;
  endfunction

  // Offer one event; the sender runs in bursts with idle gaps between them.
  // Called at a falling edge, returns at the falling edge after the transfer
  // with valid still high.
  task automatic push_event(req_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    tracker.absorb_event(r);
    @(negedge clk);
  endtask

  initial begin
    req_t r;
    int   counted;
    int   n;
    tracker = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: every descriptor, the clamp edges, all requests and
    // the stall paths, line state, suspend, bus reset and the unused kind
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0100, 16'hFFFF));
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0200, 16'h0000)); // zero length
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0200, 16'd66));
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0300, 16'h00FF));
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0301, 16'h0100)); // high bits of length
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0302, 16'd43));
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0303, 16'd18));
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0304, 16'hFFFF)); // string index too big
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h03FF, 16'hFFFF));
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h0000, 16'hFFFF)); // unknown type
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'hFF01, 16'hFFFF));
    push_event(setup_pkt(8'h80, REQ_GET_DESC, 16'h01FF, 16'h0001)); // index ignored
    push_event(setup_pkt(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF));
    push_event(setup_pkt(8'h1F, REQ_SET_CONFIG, 16'h0000, 16'h0000));
    push_event(setup_pkt(8'h21, REQ_SET_LINE, 16'h0001, 16'h0000));
    push_event(setup_pkt(8'hA1, 8'h20, 16'h0000, 16'h0007));        // other class request
    push_event(setup_pkt(8'h40, REQ_GET_DESC, 16'h0100, 16'hFFFF)); // vendor
    push_event(setup_pkt(8'hE0, REQ_SET_ADDRESS, 16'h0011, 16'h0000)); // reserved
    push_event(setup_pkt(8'h00, 8'h00, 16'h0000, 16'h0000));
    push_event(setup_pkt(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    push_event(setup_pkt(8'h21, REQ_SET_LINE, 16'hFFFE, 16'hFFFF)); // only bit 0 counts
    push_event(setup_pkt(8'h21, REQ_SET_LINE, 16'hFFFF, 16'h0000));
    r = '1;
    r.req_type = EVT_SUSPEND;
    push_event(r);
    r.req_type = EVT_BUS_RESET;
    push_event(r);
    r.req_type = EVT_UNUSED;
    push_event(r);
    push_event(setup_pkt(8'h00, REQ_SET_ADDRESS, 16'h0080, 16'h0000));

    // random part
    counted = 0;
    n       = 0;
    while (counted < EVENT_COUNT) begin
      r = random_event();
      if (r.req_type != EVT_UNUSED) counted++;
      n++;
      if (n == 120 || n == 360) hold_req = 1'b1;
      if (n == 250) begin
        // drain completely before going on
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0) @(negedge clk);
      end
      push_event(r);
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
